// ----- rtl/core/obup_pkg.sv -----
// Shared types, constants and header checks for the OBU stream parser.
`timescale 1ns / 1ps

package obup_pkg;

    // Field widths
    localparam int ACC_W  = 56;
    localparam int LEN_W  = 29;
    localparam int HLEN_W = 4;
    localparam int CNT_W  = 16;
    localparam int SBC_W  = 4;

    // Output word: OBU type .. unit count is 89 bits, padded to whole bytes
    localparam int TDATA_W = 96;
    localparam int TUSER_W = 4;

    localparam int MAX_SIZE_BYTES = 8;
    localparam logic [ACC_W-1:0] MAX_PAYLOAD_BYTES = ACC_W'(256 * 1024 * 1024);

    // Temporal delimiter OBU type
    localparam logic [3:0] OBU_TD = 4'd2;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_FORBIDDEN = 4'd1,
        ST_BADTYPE   = 4'd2,
        ST_RESERVED  = 4'd3,
        ST_NOSIZE    = 4'd4,
        ST_EXTRES    = 4'd5,
        ST_TOOLONG   = 4'd6,
        ST_TOOLARGE  = 4'd7,
        ST_SHORT     = 4'd8,
        ST_TRUNC     = 4'd9
    } status_t;

    typedef enum logic [7:0] {
        PH_START = 8'b0000_0001,
        PH_ASIZE = 8'b0000_0010,
        PH_AHDR  = 8'b0000_0100,
        PH_AEXT  = 8'b0000_1000,
        PH_EXT   = 8'b0001_0000,
        PH_SIZE  = 8'b0010_0000,
        PH_PAY5  = 8'b0100_0000,
        PH_PAYB  = 8'b1000_0000
    } phase_t;

    // Header checks in priority order; extension bits only when flagged
    function automatic status_t check_header(logic annexb, logic [7:0] hdr, logic [7:0] ext);
        status_t    st;
        logic [3:0] t;
        t  = hdr[6:3];
        st = ST_OK;
        if (hdr[7])
            st = ST_FORBIDDEN;
        else if (!(t inside {[4'd1:4'd8], 4'd15}))
            st = ST_BADTYPE;
        else if (!annexb && !hdr[1])
            st = ST_NOSIZE;
        else if (hdr[0])
            st = ST_RESERVED;
        else if (hdr[2] && (ext[2:0] != 3'd0))
            st = ST_EXTRES;
        return st;
    endfunction

endpackage

// ----- rtl/core/av1_obu_stream_parser_core.sv -----
// AV1 OBU header and LEB128 size parser, one stream byte per word.
`timescale 1ns / 1ps
// The byte that causes a result word is first held in the input register; parse logic then
//   writes the word into the result register, which drives the output.
// Throughput: one byte per cycle, sustained while the output side takes its words.
// Reset (rst_n low, asynchronous): parser waits for a new OBU, counters and annexb_mode clear,
//   both registers empty. No clearing pass is needed.

module av1_obu_stream_parser_core
(
    input  logic                         clk,
    input  logic                         rst_n,
    // configuration: annexb_mode
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [0:0]                   cfg_data,
    // input byte stream
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] in_byte
    input  logic                         s_tlast,   // stream_end
    // result words
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [3:0] OBU type, [4] extension flag, [5] size flag, [8:6] temporal_id,
    // [10:9] spatial_id, [14:11] header_length, [43:15] payload bytes,
    // [72:44] total_length, [88:73] obus_in_unit, [95:89] zero
    output logic [obup_pkg::TDATA_W-1:0] m_tdata,
    output logic [obup_pkg::TUSER_W-1:0] m_tuser    // [3:0] status
);
    import obup_pkg::*;

    // registers
    logic               annexb_reg;
    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_end_reg;
    phase_t             phase_reg, phase_next;
    logic [7:0]         hdr_reg, hdr_next;
    logic [7:0]         ext_reg, ext_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [SBC_W-1:0]   sbc_reg, sbc_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg, out_data_next;
    status_t            out_status_reg;

    logic adv;

    // parse-step signals
    logic               start;
    logic [ACC_W-1:0]   base_acc;
    logic [SBC_W-1:0]   base_sbc;
    logic [ACC_W-1:0]   sz_acc;
    logic [SBC_W-1:0]   sz_sbc;
    logic               sz_done;
    logic               sz_long;
    logic [7:0]         hd_hdr;
    logic [7:0]         hd_ext;
    logic               hd_annexb;
    logic [1:0]         hd_hb;
    status_t            hd_st;
    logic               hd_short;
    logic               hd_big;
    logic               hd_zero;
    logic [1:0]         cur_hb;
    logic [1:0]         new_hb;
    logic [LEN_W-1:0]   rem_dec;

    logic               emit;
    logic               is_fin;
    status_t            e_st;
    logic [HLEN_W-1:0]  e_hlen;
    logic [LEN_W-1:0]   e_plen;
    logic [CNT_W-1:0]   e_cnt;
    logic [LEN_W-1:0]   e_total;
    logic [2:0]         e_tid;
    logic [1:0]         e_sid;

    // handshakes
    assign cfg_ready = 1'b1;
    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_status_reg;

    // base state seen by this byte; a new OBU starts from cleared fields
    assign start    = (phase_reg == PH_START);
    assign base_acc = start ? '0 : acc_reg;
    assign base_sbc = start ? '0 : sbc_reg;
    assign cur_hb   = 2'd1 + {1'b0, hdr_reg[2]};

    // LEB128 byte: drop 7 bits into the next lane
    always_comb
    begin
        sz_acc = base_acc;
        for (int k = 0; k < MAX_SIZE_BYTES; k++)
        begin
            if (base_sbc == SBC_W'(k))
                sz_acc[7*k +: 7] = base_acc[7*k +: 7] | in_byte_reg[6:0];
        end
    end
    assign sz_sbc  = base_sbc + SBC_W'(1);
    assign sz_done = !in_byte_reg[7];
    assign sz_long = in_byte_reg[7] && (sz_sbc >= SBC_W'(MAX_SIZE_BYTES));

    // header completion checks, shared by all phases that finish a header
    assign hd_hdr    = (start || phase_reg == PH_AHDR) ? in_byte_reg : hdr_reg;
    assign hd_ext    = (phase_reg == PH_AEXT || phase_reg == PH_EXT) ? in_byte_reg : 8'h00;
    assign hd_annexb = (phase_reg == PH_AHDR || phase_reg == PH_AEXT);
    assign hd_hb     = 2'd1 + {1'b0, hd_hdr[2]};
    assign hd_st     = check_header(hd_annexb, hd_hdr, hd_ext);
    assign hd_short  = acc_reg < {{(ACC_W-2){1'b0}}, hd_hb};
    assign hd_big    = acc_reg > (MAX_PAYLOAD_BYTES + {{(ACC_W-2){1'b0}}, hd_hb});
    assign hd_zero   = acc_reg == {{(ACC_W-2){1'b0}}, hd_hb};

    assign rem_dec   = (rem_reg == '0) ? '0 : rem_reg - LEN_W'(1);

    // one parse step
    always_comb
    begin
        phase_next = phase_reg;
        hdr_next   = start ? 8'h00 : hdr_reg;
        ext_next   = start ? 8'h00 : ext_reg;
        acc_next   = base_acc;
        sbc_next   = base_sbc;
        rem_next   = start ? '0 : rem_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        is_fin     = 1'b0;
        e_st       = ST_OK;
        e_hlen     = '0;
        e_plen     = '0;
        e_cnt      = cnt_reg;

        case (phase_reg)
            PH_START, PH_ASIZE:
            begin
                if (start && !annexb_reg)
                begin
                    // section 5: this byte is the header
                    hdr_next = in_byte_reg;
                    if (in_byte_reg[2])
                        phase_next = PH_EXT;
                    else if (hd_st != ST_OK)
                    begin
                        emit   = 1'b1;
                        e_st   = hd_st;
                        e_hlen = HLEN_W'(hd_hb);
                    end
                    else
                        phase_next = PH_SIZE;
                end
                else
                begin
                    // Annex B length prefix
                    acc_next   = sz_acc;
                    sbc_next   = sz_sbc;
                    phase_next = PH_ASIZE;
                    if (sz_long)
                    begin
                        emit   = 1'b1;
                        e_st   = ST_TOOLONG;
                        e_hlen = sz_sbc;
                    end
                    else if (sz_done)
                    begin
                        if (sz_acc[ACC_W-1:32] != '0)
                        begin
                            emit   = 1'b1;
                            e_st   = ST_TOOLARGE;
                            e_hlen = sz_sbc;
                        end
                        else
                            phase_next = PH_AHDR;
                    end
                end
            end
            PH_AHDR, PH_AEXT, PH_EXT:
            begin
                if (phase_reg == PH_AHDR)
                    hdr_next = in_byte_reg;
                else
                    ext_next = in_byte_reg;
                if (phase_reg == PH_AHDR && in_byte_reg[2])
                    phase_next = PH_AEXT;
                else if (!hd_annexb)
                begin
                    if (hd_st != ST_OK)
                    begin
                        emit   = 1'b1;
                        e_st   = hd_st;
                        e_hlen = HLEN_W'(hd_hb);
                    end
                    else
                        phase_next = PH_SIZE;
                end
                else
                begin
                    e_hlen = HLEN_W'(hd_hb) + sbc_reg;
                    if (hd_st != ST_OK)
                    begin
                        emit = 1'b1;
                        e_st = hd_st;
                    end
                    else if (hd_short)
                    begin
                        emit = 1'b1;
                        e_st = ST_SHORT;
                    end
                    else if (hd_big)
                    begin
                        emit = 1'b1;
                        e_st = ST_TOOLARGE;
                    end
                    else if (hd_zero)
                    begin
                        emit   = 1'b1;
                        is_fin = 1'b1;
                    end
                    else
                    begin
                        rem_next   = acc_reg[LEN_W-1:0] - LEN_W'(hd_hb);
                        phase_next = PH_PAYB;
                    end
                end
            end
            PH_SIZE:
            begin
                // section 5 size field
                acc_next = sz_acc;
                sbc_next = sz_sbc;
                e_hlen   = HLEN_W'(cur_hb) + sz_sbc;
                if (sz_long)
                begin
                    emit = 1'b1;
                    e_st = ST_TOOLONG;
                end
                else if (sz_done)
                begin
                    if (sz_acc > MAX_PAYLOAD_BYTES)
                    begin
                        emit = 1'b1;
                        e_st = ST_TOOLARGE;
                    end
                    else if (sz_acc == '0)
                    begin
                        emit   = 1'b1;
                        is_fin = 1'b1;
                    end
                    else
                    begin
                        rem_next   = sz_acc[LEN_W-1:0];
                        phase_next = PH_PAY5;
                    end
                end
            end
            PH_PAY5, PH_PAYB:
            begin
                // count off payload bytes
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    emit   = 1'b1;
                    is_fin = 1'b1;
                    e_hlen = HLEN_W'(cur_hb) + sbc_reg;
                    e_plen = (phase_reg == PH_PAYB)
                             ? acc_reg[LEN_W-1:0] - LEN_W'(cur_hb)
                             : acc_reg[LEN_W-1:0];
                end
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase

        new_hb = 2'd1 + {1'b0, hdr_next[2]};

        // stream ended inside an OBU
        if (!emit && in_end_reg && phase_next != PH_START)
        begin
            emit = 1'b1;
            e_st = ST_TRUNC;
            case (phase_next)
                PH_ASIZE, PH_AHDR: e_hlen = sbc_next;
                PH_AEXT:           e_hlen = sbc_next + HLEN_W'(1);
                PH_EXT:            e_hlen = HLEN_W'(1);
                PH_SIZE:           e_hlen = HLEN_W'(new_hb) + sbc_next;
                PH_PAY5:
                begin
                    e_hlen = HLEN_W'(new_hb) + sbc_next;
                    e_plen = acc_next[LEN_W-1:0] - rem_next;
                end
                default:
                begin
                    e_hlen = HLEN_W'(new_hb) + sbc_next;
                    e_plen = acc_next[LEN_W-1:0] - LEN_W'(new_hb) - rem_next;
                end
            endcase
        end

        // good OBU: update the per-unit count
        if (is_fin)
        begin
            if (hdr_next[6:3] == OBU_TD)
                cnt_next = '0;
            else if (cnt_reg != '1)
                cnt_next = cnt_reg + CNT_W'(1);
            e_cnt = (hdr_next[6:3] == OBU_TD) ? cnt_reg : cnt_next;
        end

        if (emit)
            phase_next = PH_START;
    end

    assign e_total = LEN_W'(e_hlen) + e_plen;
    assign e_tid   = hdr_next[2] ? ext_next[7:5] : 3'd0;
    assign e_sid   = hdr_next[2] ? ext_next[4:3] : 2'd0;

    // result word packing
    assign out_data_next = {7'd0, e_cnt, e_total, e_plen, e_hlen, e_sid, e_tid,
                            hdr_next[1], hdr_next[2], hdr_next[6:3]};

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            annexb_reg <= 1'b0;
        else if (cfg_valid)
            annexb_reg <= cfg_data[0];
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            hdr_reg   <= '0;
            ext_reg   <= '0;
            acc_reg   <= '0;
            sbc_reg   <= '0;
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        else if (adv)
        begin
            phase_reg <= phase_next;
            hdr_reg   <= hdr_next;
            ext_reg   <= ext_next;
            acc_reg   <= acc_next;
            sbc_reg   <= sbc_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv && emit)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= e_st;
        end
    end

    // checks
    a_err_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK && m_tuser != ST_TRUNC) |-> (m_tdata[43:15] == '0))
        else $error("error word carries a payload length");

    a_hlen_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:11] <= HLEN_W'(10)))
        else $error("header length out of range");

    a_pay_remaining: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAY5 || phase_reg == PH_PAYB) |-> (rem_reg != '0))
        else $error("payload phase with nothing left to count");

    a_size_count: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SIZE || phase_reg == PH_ASIZE) |-> (sbc_reg < SBC_W'(MAX_SIZE_BYTES)))
        else $error("size byte count past limit while reading size");

endmodule
